// ===== hdl/vgatxt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgatxt_pkg
// Shared types, widths, register indexes and the colour palette of the
// text-mode pixel generator.
// ----------------------------------------------------------------------------
package vgatxt_pkg;

   // default text geometry and visible width
   localparam int TEXT_COLUMNS_DEF = 80;
   localparam int TEXT_ROWS_DEF    = 25;
   localparam int SCREEN_WIDTH_DEF = 720;

   // character cell size
   localparam int CELL_WIDTH  = 9;
   localparam int CELL_HEIGHT = 16;

   // field widths
   localparam int KIND_W   = 2;
   localparam int ADDR_W   = 12;
   localparam int DATA_W   = 8;
   localparam int PX_W     = 10;
   localparam int PY_W     = 9;
   localparam int COL_W    = 7;
   localparam int ROW_W    = 5;
   localparam int CX_W     = 4;
   localparam int RY_W     = $clog2(CELL_HEIGHT);
   localparam int IDX_W    = 4;
   localparam int COLOR_W  = 32;
   localparam int FRAME_W  = 5;
   localparam int FONT_DEPTH = 4096;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;
   localparam logic [CSR_IDX_W-1:0] CSR_CURSOR_COL = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CURSOR_ROW = 1'b1;

   // x / 9 as (x * 911) >> 13, exact for any 10-bit x
   localparam int DIV9_MUL   = 911;
   localparam int DIV9_SHIFT = 13;

   // blink phases taken from the frame counter
   localparam int CHAR_BLINK_BIT   = 4;
   localparam int CURSOR_BLINK_BIT = 3;

   // line-drawing characters that extend into the ninth column
   localparam logic [DATA_W-1:0] LINE_CHAR_FIRST = 8'd192;
   localparam logic [DATA_W-1:0] LINE_CHAR_LAST  = 8'd223;

   typedef enum logic [KIND_W-1:0] {
      KIND_TEXT_WRITE  = 2'd0,
      KIND_FONT_WRITE  = 2'd1,
      KIND_FRAME_START = 2'd2,
      KIND_RENDER      = 2'd3
   } kind_type;

   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [CX_W-1:0]  cx;
      logic [ROW_W-1:0] row;
      logic [RY_W-1:0]  ry;
      logic             outside;
   } cell_pos_type;

   function automatic logic [COLOR_W-1:0] palette_color(input logic [IDX_W-1:0] idx);
      logic [COLOR_W-1:0] c;
      case (idx)
         4'd0:    c = 32'hff000000;
         4'd1:    c = 32'hff0000aa;
         4'd2:    c = 32'hff00aa00;
         4'd3:    c = 32'hff00aaaa;
         4'd4:    c = 32'hffaa0000;
         4'd5:    c = 32'hffaa00aa;
         4'd6:    c = 32'hffaa5500;
         4'd7:    c = 32'hffaaaaaa;
         4'd8:    c = 32'hff555555;
         4'd9:    c = 32'hff5555ff;
         4'd10:   c = 32'hff55ff55;
         4'd11:   c = 32'hff55ffff;
         4'd12:   c = 32'hffff5555;
         4'd13:   c = 32'hffff55ff;
         4'd14:   c = 32'hffffff55;
         default: c = 32'hffffffff;
      endcase
      return c;
   endfunction

endpackage

// ===== hdl/vgatxt_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgatxt_if
// Valid/ready channels of the text-mode pixel generator: request items in,
// pixel colours out.
// ----------------------------------------------------------------------------
interface vgatxt_req_if;
   logic                          valid;
   logic                          ready;
   logic [vgatxt_pkg::KIND_W-1:0] kind;
   logic [vgatxt_pkg::ADDR_W-1:0] address;
   logic [vgatxt_pkg::DATA_W-1:0] data;
   logic [vgatxt_pkg::PX_W-1:0]   pixel_x;
   logic [vgatxt_pkg::PY_W-1:0]   pixel_y;

   modport source (output valid, kind, address, data, pixel_x, pixel_y, input ready);
   modport sink   (input valid, kind, address, data, pixel_x, pixel_y, output ready);
endinterface

interface vgatxt_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [vgatxt_pkg::IDX_W-1:0]   color_index;
   logic [vgatxt_pkg::COLOR_W-1:0] pixel_color;

   modport source (output valid, color_index, pixel_color, input ready);
   modport sink   (input valid, color_index, pixel_color, output ready);
endinterface

// ===== hdl/vgatxt_cell_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgatxt_cell_map
// Maps a screen pixel to its text cell, the position inside the cell and
// a flag for pixels beyond the text area.
// ----------------------------------------------------------------------------
module vgatxt_cell_map #(
   parameter int TEXT_COLUMNS = vgatxt_pkg::TEXT_COLUMNS_DEF,
   parameter int TEXT_ROWS    = vgatxt_pkg::TEXT_ROWS_DEF,
   parameter int SCREEN_WIDTH = vgatxt_pkg::SCREEN_WIDTH_DEF
) (
   input  logic [vgatxt_pkg::PX_W-1:0] pixel_x,
   input  logic [vgatxt_pkg::PY_W-1:0] pixel_y,
   output vgatxt_pkg::cell_pos_type    pos
);

   localparam int PROD_W = vgatxt_pkg::PX_W + $clog2(vgatxt_pkg::DIV9_MUL + 1);

   logic [PROD_W-1:0]               prod;
   logic [vgatxt_pkg::COL_W-1:0]    col;
   logic [vgatxt_pkg::PX_W-1:0]     col_x9;
   logic [vgatxt_pkg::PX_W-1:0]     rem;
   logic [vgatxt_pkg::ROW_W-1:0]    row;

   // divide by the cell width through a reciprocal
   assign prod   = PROD_W'(pixel_x) * PROD_W'(vgatxt_pkg::DIV9_MUL);
   assign col    = prod[vgatxt_pkg::DIV9_SHIFT +: vgatxt_pkg::COL_W];
   assign col_x9 = vgatxt_pkg::PX_W'(col) * vgatxt_pkg::PX_W'(vgatxt_pkg::CELL_WIDTH);
   assign rem    = pixel_x - col_x9;
   assign row    = pixel_y[vgatxt_pkg::PY_W-1:vgatxt_pkg::RY_W];

   assign pos.col     = col;
   assign pos.cx      = rem[vgatxt_pkg::CX_W-1:0];
   assign pos.row     = row;
   assign pos.ry      = pixel_y[vgatxt_pkg::RY_W-1:0];
   assign pos.outside = (int'(pixel_x) >= SCREEN_WIDTH) || (int'(col) >= TEXT_COLUMNS) ||
                        (int'(row) >= TEXT_ROWS);

endmodule

// ===== hdl/vga_text_mode_pixel_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vga_text_mode_pixel_generator
// Text-mode pixel generator: text and font memories, blink and cursor logic.
// ----------------------------------------------------------------------------
// Items arrive on req_chan (valid/ready): write a text byte (even address is
// the character, odd the attribute), write a font row, mark a frame start,
// or render pixel (pixel_x, pixel_y). Only render items produce a
// transaction on rsp_chan, carrying the palette index and its ARGB word.
// csr_write_enable with csr_index writes the cursor column or row; write
// these only while the block is idle.
// The block is a four-stage pipeline and takes one item every cycle while
// its results are taken. The text memories are read in the second stage and
// the font memory, addressed by the character just read, in the third.
// Writes land in the stage where the same memory is read, so items always
// see the memory in request order.
// Reset clears the pipeline, the frame counter and the cursor position; the
// memories hold no defined contents until written. When rsp_chan.ready is
// low the result is held and the stages behind it keep filling until the
// pipeline is full, then req_chan.ready drops.
// ----------------------------------------------------------------------------
module vga_text_mode_pixel_generator #(
   parameter int TEXT_COLUMNS = vgatxt_pkg::TEXT_COLUMNS_DEF,
   parameter int TEXT_ROWS    = vgatxt_pkg::TEXT_ROWS_DEF,
   parameter int SCREEN_WIDTH = vgatxt_pkg::SCREEN_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   vgatxt_req_if.sink                         req_chan,
   vgatxt_rsp_if.source                       rsp_chan,
   input  logic                               csr_write_enable,
   input  logic [vgatxt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [vgatxt_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   localparam int CELLS      = TEXT_COLUMNS * TEXT_ROWS;
   localparam int CELL_W     = $clog2(CELLS);
   localparam int TEXT_BYTES = 2 * CELLS;
   localparam int SUM_W      = vgatxt_pkg::ROW_W + $clog2(TEXT_COLUMNS + 1) + 1;
   localparam int AEXT_W     = vgatxt_pkg::ADDR_W + 1;

   // cursor and frame counter registers
   logic [vgatxt_pkg::COL_W-1:0]   cursor_col_ff;
   logic [vgatxt_pkg::ROW_W-1:0]   cursor_row_ff;
   logic [vgatxt_pkg::FRAME_W-1:0] frame_ff;
   logic [vgatxt_pkg::FRAME_W-1:0] frame_in;

   // stage handshakes
   logic rdy_a, rdy_b, rdy_c, rdy_d;
   logic mov_ab, mov_bc, mov_cd;

   // stage A
   logic                           a_valid_ff;
   vgatxt_pkg::kind_type           a_kind_ff;
   logic [vgatxt_pkg::ADDR_W-1:0]  a_address_ff;
   logic [vgatxt_pkg::DATA_W-1:0]  a_data_ff;
   vgatxt_pkg::cell_pos_type       a_pos_ff;
   vgatxt_pkg::cell_pos_type       req_pos;

   // stage B
   logic                           b_valid_ff;
   vgatxt_pkg::kind_type           b_kind_ff;
   logic [vgatxt_pkg::ADDR_W-1:0]  b_address_ff;
   logic [vgatxt_pkg::DATA_W-1:0]  b_data_ff;
   vgatxt_pkg::cell_pos_type       b_pos_ff;
   logic [vgatxt_pkg::DATA_W-1:0]  b_char_ff;
   logic [vgatxt_pkg::DATA_W-1:0]  b_attr_ff;

   // stage C
   logic                           c_valid_ff;
   vgatxt_pkg::kind_type           c_kind_ff;
   logic [vgatxt_pkg::CX_W-1:0]    c_cx_ff;
   logic                           c_outside_ff;
   logic                           c_cursor_ff;
   logic [vgatxt_pkg::DATA_W-1:0]  c_char_ff;
   logic [vgatxt_pkg::DATA_W-1:0]  c_attr_ff;
   logic [vgatxt_pkg::DATA_W-1:0]  c_font_ff;

   // result register
   logic                           rsp_valid_ff;
   logic [vgatxt_pkg::IDX_W-1:0]   rsp_index_ff;
   logic [vgatxt_pkg::COLOR_W-1:0] rsp_color_ff;

   // memories
   logic [vgatxt_pkg::DATA_W-1:0]  char_mem [CELLS];
   logic [vgatxt_pkg::DATA_W-1:0]  attr_mem [CELLS];
   logic [vgatxt_pkg::DATA_W-1:0]  font_mem [vgatxt_pkg::FONT_DEPTH];

   logic [SUM_W-1:0]                 cell_sum;
   logic [CELL_W-1:0]                text_rd_addr;
   logic [AEXT_W-1:0]                a_address_ext;
   logic [CELL_W-1:0]                text_wr_addr;
   logic                             text_in_range;
   logic [vgatxt_pkg::ADDR_W-1:0]    font_rd_addr;
   logic                             cursor_in;

   logic [vgatxt_pkg::IDX_W-1:0]     bg;
   logic [vgatxt_pkg::IDX_W-1:0]     fg;
   logic                             glyph;
   logic [vgatxt_pkg::IDX_W-1:0]     index_in;

   vgatxt_cell_map #(
      .TEXT_COLUMNS (TEXT_COLUMNS),
      .TEXT_ROWS    (TEXT_ROWS),
      .SCREEN_WIDTH (SCREEN_WIDTH)
   ) u_cell_map (
      .pixel_x (req_chan.pixel_x),
      .pixel_y (req_chan.pixel_y),
      .pos     (req_pos)
   );

   // ---------------------------------------------------------------- flow
   assign rdy_d  = !rsp_valid_ff || rsp_chan.ready;
   assign mov_cd = c_valid_ff && rdy_d;
   assign rdy_c  = !c_valid_ff || rdy_d;
   assign mov_bc = b_valid_ff && rdy_c;
   assign rdy_b  = !b_valid_ff || rdy_c;
   assign mov_ab = a_valid_ff && rdy_b;
   assign rdy_a  = !a_valid_ff || rdy_b;

   assign req_chan.ready = rdy_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rdy_a) begin
            a_valid_ff <= req_chan.valid;
         end
         if (rdy_b) begin
            b_valid_ff <= a_valid_ff;
         end
         if (rdy_c) begin
            c_valid_ff <= b_valid_ff;
         end
         if (rdy_d) begin
            rsp_valid_ff <= c_valid_ff && (c_kind_ff == vgatxt_pkg::KIND_RENDER);
         end
      end
   end

   // ------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_col_ff <= '0;
         cursor_row_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            vgatxt_pkg::CSR_CURSOR_COL: cursor_col_ff <= csr_write_data;
            vgatxt_pkg::CSR_CURSOR_ROW: cursor_row_ff <= csr_write_data[vgatxt_pkg::ROW_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------- stage A
   always_ff @(posedge clock) begin
      if (rdy_a) begin
         a_kind_ff    <= vgatxt_pkg::kind_type'(req_chan.kind);
         a_address_ff <= req_chan.address;
         a_data_ff    <= req_chan.data;
         a_pos_ff     <= req_pos;
      end
   end

   // ------------------------------------------------- text memories, A->B
   assign cell_sum = SUM_W'(a_pos_ff.row) * SUM_W'(TEXT_COLUMNS) + SUM_W'(a_pos_ff.col);
   // park the read address for pixels off the grid
   assign text_rd_addr  = a_pos_ff.outside ? '0 : cell_sum[CELL_W-1:0];
   assign a_address_ext = AEXT_W'(a_address_ff);
   assign text_wr_addr  = a_address_ext[CELL_W:1];
   assign text_in_range = int'(a_address_ff) < TEXT_BYTES;

   always_ff @(posedge clock) begin
      if (mov_ab && (a_kind_ff == vgatxt_pkg::KIND_TEXT_WRITE) && text_in_range) begin
         if (a_address_ff[0]) begin
            attr_mem[text_wr_addr] <= a_data_ff;
         end else begin
            char_mem[text_wr_addr] <= a_data_ff;
         end
      end
      if (rdy_b) begin
         b_char_ff <= char_mem[text_rd_addr];
         b_attr_ff <= attr_mem[text_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_b) begin
         b_kind_ff    <= a_kind_ff;
         b_address_ff <= a_address_ff;
         b_data_ff    <= a_data_ff;
         b_pos_ff     <= a_pos_ff;
      end
   end

   // ---------------------------------------------------- font memory, B->C
   assign font_rd_addr = {b_char_ff, b_pos_ff.ry};
   assign cursor_in    = (b_pos_ff.col == cursor_col_ff) && (b_pos_ff.row == cursor_row_ff) &&
                         (b_pos_ff.ry[vgatxt_pkg::RY_W-1:1] == '1);

   always_ff @(posedge clock) begin
      if (mov_bc && (b_kind_ff == vgatxt_pkg::KIND_FONT_WRITE)) begin
         font_mem[b_address_ff] <= b_data_ff;
      end
      if (rdy_c) begin
         c_font_ff <= font_mem[font_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_c) begin
         c_kind_ff    <= b_kind_ff;
         c_cx_ff      <= b_pos_ff.cx;
         c_outside_ff <= b_pos_ff.outside;
         c_cursor_ff  <= cursor_in;
         c_char_ff    <= b_char_ff;
         c_attr_ff    <= b_attr_ff;
      end
   end

   // ------------------------------------------------------ colour, C->D
   always_comb begin
      bg = {1'b0, c_attr_ff[6:4]};
      fg = (!c_attr_ff[7] || frame_ff[vgatxt_pkg::CHAR_BLINK_BIT]) ? c_attr_ff[3:0] : bg;
      if (c_cx_ff < vgatxt_pkg::CX_W'(8)) begin
         glyph = c_font_ff[~c_cx_ff[2:0]];
      end else begin
         // ninth column: repeat the eighth for line-drawing characters
         glyph = (c_char_ff inside {[vgatxt_pkg::LINE_CHAR_FIRST:vgatxt_pkg::LINE_CHAR_LAST]}) &&
                 c_font_ff[0];
      end
      if (c_outside_ff) begin
         index_in = '0;
      end else if (c_cursor_ff && frame_ff[vgatxt_pkg::CURSOR_BLINK_BIT]) begin
         index_in = c_attr_ff[3:0];
      end else begin
         index_in = glyph ? fg : bg;
      end
   end

   assign frame_in = frame_ff + vgatxt_pkg::FRAME_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
      end else if (mov_cd && (c_kind_ff == vgatxt_pkg::KIND_FRAME_START)) begin
         frame_ff <= frame_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_d) begin
         rsp_index_ff <= index_in;
         rsp_color_ff <= vgatxt_pkg::palette_color(index_in);
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.color_index = rsp_index_ff;
   assign rsp_chan.pixel_color = rsp_color_ff;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the text-mode pixel generator. A shadow copy of
// the text store, the font store, the frame counter and the cursor tracks
// every accepted transaction and predicts the colour of each rendered
// pixel. Directed cases cover the corners and the ninth column, a frame
// sweep covers both blink phases and the counter wrap, and random traffic
// covers the rest under random idling, one long result hold-off and a final
// stretch at full rate.
// ----------------------------------------------------------------------------
module tb;

   localparam int TEXT_BYTES      = 2 * vgatxt_pkg::TEXT_COLUMNS_DEF *
                                    vgatxt_pkg::TEXT_ROWS_DEF;
   localparam int CURSOR_TOP_LINE = vgatxt_pkg::CELL_HEIGHT - 2;
   localparam int SETTLE_CYCLES   = 8;
   localparam int DRAIN_CYCLES    = 16;
   localparam int HOLD_CYCLES     = 300;
   localparam int CYCLE_LIMIT     = 500_000;
   localparam int RANDOM_CHUNK    = 240;

   // palette, entry 15 in the top word
   localparam logic [16*vgatxt_pkg::COLOR_W-1:0] ARGB_TABLE = {
      32'hffffffff, 32'hffffff55, 32'hffff55ff, 32'hffff5555,
      32'hff55ffff, 32'hff55ff55, 32'hff5555ff, 32'hff555555,
      32'hffaaaaaa, 32'hffaa5500, 32'hffaa00aa, 32'hffaa0000,
      32'hff00aaaa, 32'hff00aa00, 32'hff0000aa, 32'hff000000
   };

   typedef struct packed {
      logic [vgatxt_pkg::IDX_W-1:0]   idx;
      logic [vgatxt_pkg::COLOR_W-1:0] argb;
   } pixel_expect_type;

   logic clock = 1'b0;
   logic reset;
   logic                              csr_write_enable;
   logic [vgatxt_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [vgatxt_pkg::CSR_DATA_W-1:0] csr_write_data;

   vgatxt_req_if req_chan();
   vgatxt_rsp_if rsp_chan();

   vga_text_mode_pixel_generator u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // shadow state of the block
   logic [vgatxt_pkg::DATA_W-1:0]  text_shadow [0:TEXT_BYTES-1];
   bit                             text_known  [0:TEXT_BYTES-1];
   logic [vgatxt_pkg::DATA_W-1:0]  font_shadow [0:vgatxt_pkg::FONT_DEPTH-1];
   bit                             font_known  [0:vgatxt_pkg::FONT_DEPTH-1];
   logic [vgatxt_pkg::FRAME_W-1:0] frame_count;
   logic [vgatxt_pkg::COL_W-1:0]   cursor_col_q;
   logic [vgatxt_pkg::ROW_W-1:0]   cursor_row_q;

   pixel_expect_type expected_pixels[$];

   int  errors = 0;
   int  pixels_checked = 0;
   int  item_count = 0;
   int  text_writes = 0;
   int  font_writes = 0;
   int  frame_starts = 0;
   int  cursor_settings = 0;
   int  cycle_count = 0;
   int  hold_requests = 0;
   bit  sender_idle = 1'b1;
   bit  receiver_idle = 1'b1;

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d pixels outstanding", $time,
                  cycle_count, expected_pixels.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------
   function automatic logic [vgatxt_pkg::IDX_W-1:0] pixel_index(
      input logic [vgatxt_pkg::PX_W-1:0] px,
      input logic [vgatxt_pkg::PY_W-1:0] py);
      int col, row, cx, ry, cell_no;
      logic [vgatxt_pkg::DATA_W-1:0] ch, attr, glyph;
      logic [vgatxt_pkg::IDX_W-1:0]  bg, fg;
      logic                          lit;
      col = px / vgatxt_pkg::CELL_WIDTH;
      row = py / vgatxt_pkg::CELL_HEIGHT;
      cx  = px % vgatxt_pkg::CELL_WIDTH;
      ry  = py % vgatxt_pkg::CELL_HEIGHT;
      if (px >= vgatxt_pkg::SCREEN_WIDTH_DEF || col >= vgatxt_pkg::TEXT_COLUMNS_DEF ||
          row >= vgatxt_pkg::TEXT_ROWS_DEF)
         return '0;
      cell_no = row * vgatxt_pkg::TEXT_COLUMNS_DEF + col;
      ch   = text_shadow[2 * cell_no];
      attr = text_shadow[2 * cell_no + 1];
      if (frame_count[vgatxt_pkg::CURSOR_BLINK_BIT] && col == cursor_col_q &&
          row == cursor_row_q && ry >= CURSOR_TOP_LINE)
         return attr[3:0];
      bg = {1'b0, attr[6:4]};
      fg = (attr[7] && !frame_count[vgatxt_pkg::CHAR_BLINK_BIT]) ? bg : attr[3:0];
      glyph = font_shadow[{ch, ry[vgatxt_pkg::RY_W-1:0]}];
      if (cx < 8)
         lit = glyph[7 - cx];
      else if (ch >= vgatxt_pkg::LINE_CHAR_FIRST && ch <= vgatxt_pkg::LINE_CHAR_LAST)
         lit = glyph[0];
      else
         return bg;
      return lit ? fg : bg;
   endfunction

   function automatic void track_item(input vgatxt_pkg::kind_type kind,
                                      input logic [vgatxt_pkg::ADDR_W-1:0] address,
                                      input logic [vgatxt_pkg::DATA_W-1:0] data,
                                      input logic [vgatxt_pkg::PX_W-1:0] px,
                                      input logic [vgatxt_pkg::PY_W-1:0] py);
      logic [vgatxt_pkg::IDX_W-1:0] idx;
      case (kind)
         vgatxt_pkg::KIND_TEXT_WRITE: begin
            // writes past the end of the text store are dropped
            if (address < TEXT_BYTES) begin
               text_shadow[address] = data;
               text_known[address]  = 1'b1;
               text_writes++;
               item_count++;
            end
         end
         vgatxt_pkg::KIND_FONT_WRITE: begin
            font_shadow[address] = data;
            font_known[address]  = 1'b1;
            font_writes++;
            item_count++;
         end
         vgatxt_pkg::KIND_FRAME_START: begin
            frame_count = frame_count + 1'b1;
            frame_starts++;
            item_count++;
         end
         default: begin
            idx = pixel_index(px, py);
            expected_pixels.push_back(pixel_expect_type'{idx,
               ARGB_TABLE[idx*vgatxt_pkg::COLOR_W +: vgatxt_pkg::COLOR_W]});
            item_count++;
         end
      endcase
   endfunction

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------
   task automatic send_item(input vgatxt_pkg::kind_type kind,
                            input logic [vgatxt_pkg::ADDR_W-1:0] address,
                            input logic [vgatxt_pkg::DATA_W-1:0] data,
                            input logic [vgatxt_pkg::PX_W-1:0] px,
                            input logic [vgatxt_pkg::PY_W-1:0] py);
      if (sender_idle && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.kind    <= kind;
      req_chan.address <= address;
      req_chan.data    <= data;
      req_chan.pixel_x <= px;
      req_chan.pixel_y <= py;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      track_item(kind, address, data, px, py);
      // leave valid up: the next call either drops it or replaces the payload
      @(negedge clock);
   endtask

   task automatic put_text(input logic [vgatxt_pkg::ADDR_W-1:0] address,
                           input logic [vgatxt_pkg::DATA_W-1:0] data);
      send_item(vgatxt_pkg::KIND_TEXT_WRITE, address, data,
                vgatxt_pkg::PX_W'($urandom), vgatxt_pkg::PY_W'($urandom));
   endtask

   task automatic put_font(input logic [vgatxt_pkg::ADDR_W-1:0] address,
                           input logic [vgatxt_pkg::DATA_W-1:0] data);
      send_item(vgatxt_pkg::KIND_FONT_WRITE, address, data,
                vgatxt_pkg::PX_W'($urandom), vgatxt_pkg::PY_W'($urandom));
   endtask

   task automatic next_frame();
      send_item(vgatxt_pkg::KIND_FRAME_START, vgatxt_pkg::ADDR_W'($urandom),
                vgatxt_pkg::DATA_W'($urandom),
                vgatxt_pkg::PX_W'($urandom), vgatxt_pkg::PY_W'($urandom));
   endtask

   task automatic put_pixel(input logic [vgatxt_pkg::PX_W-1:0] px,
                            input logic [vgatxt_pkg::PY_W-1:0] py);
      send_item(vgatxt_pkg::KIND_RENDER, vgatxt_pkg::ADDR_W'($urandom),
                vgatxt_pkg::DATA_W'($urandom), px, py);
   endtask

   function automatic logic [vgatxt_pkg::DATA_W-1:0] random_char();
      case ($urandom_range(0, 3))
         0:       return vgatxt_pkg::DATA_W'($urandom_range(vgatxt_pkg::LINE_CHAR_FIRST,
                                                              vgatxt_pkg::LINE_CHAR_LAST));
         1:       return vgatxt_pkg::DATA_W'($urandom_range(vgatxt_pkg::LINE_CHAR_FIRST - 2,
                                                              vgatxt_pkg::LINE_CHAR_LAST + 2));
         default: return vgatxt_pkg::DATA_W'($urandom);
      endcase
   endfunction

   function automatic logic [vgatxt_pkg::DATA_W-1:0] random_glyph_row();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return '1;
         default: return vgatxt_pkg::DATA_W'($urandom);
      endcase
   endfunction

   function automatic logic [vgatxt_pkg::PX_W-1:0] grid_x();
      return vgatxt_pkg::PX_W'($urandom_range(0, vgatxt_pkg::SCREEN_WIDTH_DEF - 1));
   endfunction

   function automatic logic [vgatxt_pkg::PY_W-1:0] grid_y();
      return vgatxt_pkg::PY_W'($urandom_range(0, vgatxt_pkg::TEXT_ROWS_DEF *
                                                 vgatxt_pkg::CELL_HEIGHT - 1));
   endfunction

   // render a pixel, first filling whatever store entries it would read
   task automatic show_pixel(input logic [vgatxt_pkg::PX_W-1:0] px,
                             input logic [vgatxt_pkg::PY_W-1:0] py);
      int cell_no, ry;
      logic [vgatxt_pkg::ADDR_W-1:0] row_addr;
      if (px < vgatxt_pkg::SCREEN_WIDTH_DEF &&
          px / vgatxt_pkg::CELL_WIDTH < vgatxt_pkg::TEXT_COLUMNS_DEF &&
          py / vgatxt_pkg::CELL_HEIGHT < vgatxt_pkg::TEXT_ROWS_DEF) begin
         cell_no = (py / vgatxt_pkg::CELL_HEIGHT) * vgatxt_pkg::TEXT_COLUMNS_DEF +
                   px / vgatxt_pkg::CELL_WIDTH;
         ry = py % vgatxt_pkg::CELL_HEIGHT;
         if (!text_known[2 * cell_no])
            put_text(vgatxt_pkg::ADDR_W'(2 * cell_no), random_char());
         if (!text_known[2 * cell_no + 1])
            put_text(vgatxt_pkg::ADDR_W'(2 * cell_no + 1), vgatxt_pkg::DATA_W'($urandom));
         row_addr = {text_shadow[2 * cell_no], ry[vgatxt_pkg::RY_W-1:0]};
         if (!font_known[row_addr])
            put_font(row_addr, random_glyph_row());
      end
      put_pixel(px, py);
   endtask

   // drain the pipeline, then write both cursor registers
   task automatic program_cursor(input logic [vgatxt_pkg::CSR_DATA_W-1:0] col,
                                 input logic [vgatxt_pkg::CSR_DATA_W-1:0] row);
      req_chan.valid <= 1'b0;
      while (expected_pixels.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= vgatxt_pkg::CSR_CURSOR_COL;
      csr_write_data   <= col;
      @(negedge clock);
      cursor_col_q   = col[vgatxt_pkg::COL_W-1:0];
      csr_index      <= vgatxt_pkg::CSR_CURSOR_ROW;
      csr_write_data <= row;
      @(negedge clock);
      cursor_row_q     = row[vgatxt_pkg::ROW_W-1:0];
      csr_write_enable <= 1'b0;
      cursor_settings++;
   endtask

   // ------------------------------------------------------------------
   // result side
   // ------------------------------------------------------------------
   initial begin : result_side
      int stall_left;
      int hold_left;
      int holds_seen;
      stall_left = 0;
      hold_left  = 0;
      holds_seen = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_seen) begin
            holds_seen = hold_requests;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (receiver_idle && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 15);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      pixel_expect_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_pixels.size() == 0) begin
            errors++;
            $display("%0t: unexpected pixel transaction, expected none, got index %0d colour %h",
                     $time, rsp_chan.color_index, rsp_chan.pixel_color);
         end else begin
            want = expected_pixels.pop_front();
            pixels_checked++;
            if (rsp_chan.color_index !== want.idx) begin
               errors++;
               $display("%0t: colour index mismatch, expected %0d, got %0d", $time,
                        want.idx, rsp_chan.color_index);
            end
            if (rsp_chan.pixel_color !== want.argb) begin
               errors++;
               $display("%0t: pixel colour mismatch, expected %h, got %h", $time,
                        want.argb, rsp_chan.pixel_color);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   task automatic test_directed();
      // line character in the top-left cell, ninth column repeats column 7
      put_text(12'd0, vgatxt_pkg::LINE_CHAR_FIRST);
      put_text(12'd1, 8'h1e);
      put_font({vgatxt_pkg::LINE_CHAR_FIRST, 4'd0}, 8'h81);
      put_pixel(10'd0, 9'd0);
      put_pixel(10'd1, 9'd0);
      put_pixel(10'd8, 9'd0);
      // last cell, last line, last column
      put_text(vgatxt_pkg::ADDR_W'(TEXT_BYTES - 2), vgatxt_pkg::LINE_CHAR_LAST);
      put_text(vgatxt_pkg::ADDR_W'(TEXT_BYTES - 1), 8'h7f);
      put_font({vgatxt_pkg::LINE_CHAR_LAST, 4'd15}, 8'h01);
      put_pixel(10'd719, 9'd399);
      put_pixel(10'd711, 9'd399);
      // writes past the text store must not alias onto it
      put_text(vgatxt_pkg::ADDR_W'(TEXT_BYTES), 8'h00);
      put_text(12'hfff, 8'hff);
      put_pixel(10'd8, 9'd0);
      // outside the text area
      put_pixel(10'd720, 9'd0);
      put_pixel(10'd1023, 9'd511);
      put_pixel(10'd0, 9'd400);
      // glyph 255 row 15 is the top font entry; not a line character
      put_text(12'd2, 8'hff);
      put_text(12'd3, 8'h70);
      put_font(12'hfff, 8'hff);
      put_pixel(10'd17, 9'd15);
      put_pixel(10'd9, 9'd15);
      // first code past the line range shows background in column 8
      put_text(12'd4, vgatxt_pkg::LINE_CHAR_LAST + 8'd1);
      put_text(12'd5, 8'h2d);
      put_font({vgatxt_pkg::LINE_CHAR_LAST + 8'd1, 4'd3}, 8'hff);
      put_pixel(10'd26, 9'd3);
   endtask

   // walk the frame counter through both blink phases and past the wrap
   task automatic test_frame_wrap();
      put_text(12'd6, random_char());
      put_text(12'd7, 8'hc9);
      repeat (2 * (1 << vgatxt_pkg::FRAME_W) + 2) begin
         next_frame();
         show_pixel(vgatxt_pkg::PX_W'($urandom_range(0, vgatxt_pkg::CELL_WIDTH - 1)),
                    vgatxt_pkg::PY_W'($urandom_range(CURSOR_TOP_LINE,
                                                      vgatxt_pkg::CELL_HEIGHT - 1)));
         show_pixel(vgatxt_pkg::PX_W'(3 * vgatxt_pkg::CELL_WIDTH +
                                      $urandom_range(0, vgatxt_pkg::CELL_WIDTH - 1)),
                    vgatxt_pkg::PY_W'($urandom_range(0, vgatxt_pkg::CELL_HEIGHT - 1)));
      end
   endtask

   task automatic test_random_traffic(input int count);
      int target;
      int pick;
      target = item_count + count;
      while (item_count < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 50)
            show_pixel(grid_x(), grid_y());
         else if (pick < 60 && cursor_col_q < vgatxt_pkg::TEXT_COLUMNS_DEF &&
                  cursor_row_q < vgatxt_pkg::TEXT_ROWS_DEF)
            show_pixel(vgatxt_pkg::PX_W'(cursor_col_q * vgatxt_pkg::CELL_WIDTH +
                                         $urandom_range(0, vgatxt_pkg::CELL_WIDTH - 1)),
                       vgatxt_pkg::PY_W'(cursor_row_q * vgatxt_pkg::CELL_HEIGHT +
                                         $urandom_range(CURSOR_TOP_LINE,
                                                        vgatxt_pkg::CELL_HEIGHT - 1)));
         else if (pick < 72)
            put_text(vgatxt_pkg::ADDR_W'($urandom),
                     (pick & 1) ? random_char() : vgatxt_pkg::DATA_W'($urandom));
         else if (pick < 84)
            put_font(vgatxt_pkg::ADDR_W'($urandom), random_glyph_row());
         else if (pick < 90)
            next_frame();
         else
            show_pixel(vgatxt_pkg::PX_W'($urandom), vgatxt_pkg::PY_W'($urandom));
      end
   endtask

   // hold results back long enough for the pipeline to fill and stall input
   task automatic test_backpressure();
      bit keep_idle;
      keep_idle   = sender_idle;
      sender_idle = 1'b0;
      hold_requests++;
      repeat (40) show_pixel(grid_x(), grid_y());
      sender_idle = keep_idle;
   endtask

   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = vgatxt_pkg::CSR_CURSOR_COL;
      csr_write_data   = '0;
      req_chan.valid   = 1'b0;
      req_chan.kind    = vgatxt_pkg::KIND_TEXT_WRITE;
      req_chan.address = '0;
      req_chan.data    = '0;
      req_chan.pixel_x = '0;
      req_chan.pixel_y = '0;
      frame_count      = '0;
      cursor_col_q     = '0;
      cursor_row_q     = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      program_cursor(7'd0, 7'd0);
      test_directed();
      test_frame_wrap();

      program_cursor(7'd79, 7'd24);
      test_random_traffic(RANDOM_CHUNK);
      program_cursor(7'h7f, 7'h7f);
      test_random_traffic(RANDOM_CHUNK);
      program_cursor(vgatxt_pkg::CSR_DATA_W'($urandom_range(0, 79)),
                     vgatxt_pkg::CSR_DATA_W'($urandom_range(0, 24)));
      test_backpressure();
      test_random_traffic(RANDOM_CHUNK);
      program_cursor(7'd80, 7'd25);
      test_random_traffic(RANDOM_CHUNK);
      program_cursor(vgatxt_pkg::CSR_DATA_W'($urandom_range(0, 79)),
                     vgatxt_pkg::CSR_DATA_W'($urandom_range(0, 24)));
      test_random_traffic(RANDOM_CHUNK);

      // full rate on both sides to the end
      sender_idle   = 1'b0;
      receiver_idle = 1'b0;
      program_cursor(vgatxt_pkg::CSR_DATA_W'($urandom_range(0, 79)),
                     vgatxt_pkg::CSR_DATA_W'($urandom_range(0, 24)));
      test_random_traffic(RANDOM_CHUNK);

      req_chan.valid <= 1'b0;
      while (expected_pixels.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d pixels against %0d text writes, %0d font rows, %0d frame starts",
               pixels_checked, text_writes, font_writes, frame_starts);
      $display("over %0d cursor settings in %0d cycles, %0d errors", cursor_settings,
               cycle_count, errors);
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
